// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the register access master RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== rtl/i2cra_pkg.sv =====
// Types, constants and helper functions of the I2C register access master.
// Used by i2cra_step and i2c_register_access_master; no dependencies.
package i2cra_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [6:0] WRITE_TICKS = 7'd91;
    localparam logic [6:0] READ_TICKS  = 7'd123;
    localparam logic [7:0] READ_BIT    = 8'h01;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [6:0] phase;
        logic       kind;
        logic [7:0] addr;
        logic [7:0] regad;
        logic [7:0] data;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       nack;
    } state_t;

    typedef struct packed {
        logic       nack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    typedef struct packed {
        logic [2:0] quot;
        logic [1:0] rem;
    } div3_t;

    // Split a bit slot offset below 24 into bit number and tick within the bit.
    function automatic div3_t div3(input logic [4:0] val);
        logic [8:0] prod;
        logic [4:0] rem5;
        div3_t      res;
        prod     = {4'b0000, val} * 9'd11;
        res.quot = prod[7:5];
        rem5     = val - {1'b0, res.quot, 1'b0} - {2'b00, res.quot};
        res.rem  = rem5[1:0];
        return res;
    endfunction

endpackage

// ===== rtl/i2cra_step.sv =====
// Combinational sequencer step of the I2C register access master.
// Depends on i2cra_pkg for the state, item and result types.
module i2cra_step (
    input  i2cra_pkg::state_t  cur,
    input  i2cra_pkg::item_t   item,
    output i2cra_pkg::state_t  nxt,
    output i2cra_pkg::result_t res
);
    import i2cra_pkg::*;

    typedef enum logic [2:0] {
        SEG_START,
        SEG_SEND,
        SEG_RECV,
        SEG_MNACK,
        SEG_STOP
    } seg_t;

    always_comb
    begin
        state_t     st;
        logic [6:0] p;
        logic [6:0] off7;
        logic [4:0] off;
        logic [4:0] q5;
        logic [6:0] total;
        logic [7:0] tx_byte;
        seg_t       seg;
        div3_t      dq;
        logic       busy;
        logic       done;

        st      = cur;
        busy    = 1'b0;
        done    = 1'b0;
        tx_byte = st.addr;
        seg     = SEG_START;
        off7    = 7'd0;
        q5      = 5'd0;
        dq      = '0;
        total   = WRITE_TICKS;

        if (cur.phase == 7'd0 && (item.req_type == REQ_WRITE || item.req_type == REQ_READ))
        begin
            st.kind  = (item.req_type == REQ_READ);
            st.addr  = item.dev_addr;
            st.regad = item.reg_addr;
            st.data  = item.wdata;
            st.nack  = 1'b0;
            if (item.req_type == REQ_READ)
            begin
                st.shift = 8'h00;
            end
            st.phase = 7'd1;
        end

        p = st.phase - 7'd1;

        if (p < 7'd4)
        begin
            seg  = SEG_START;
            off7 = p;
        end
        else if (p < 7'd32)
        begin
            seg     = SEG_SEND;
            tx_byte = st.addr;
            off7    = p - 7'd4;
        end
        else if (p < 7'd60)
        begin
            seg     = SEG_SEND;
            tx_byte = st.regad;
            off7    = p - 7'd32;
        end
        else if (!st.kind)
        begin
            if (p < 7'd88)
            begin
                seg     = SEG_SEND;
                tx_byte = st.data;
                off7    = p - 7'd60;
            end
            else
            begin
                seg  = SEG_STOP;
                off7 = p - 7'd88;
            end
        end
        else if (p < 7'd64)
        begin
            seg  = SEG_START;
            off7 = p - 7'd60;
        end
        else if (p < 7'd92)
        begin
            seg     = SEG_SEND;
            tx_byte = st.addr | READ_BIT;
            off7    = p - 7'd64;
        end
        else if (p < 7'd117)
        begin
            seg  = SEG_RECV;
            off7 = p - 7'd92;
        end
        else if (p < 7'd120)
        begin
            seg  = SEG_MNACK;
            off7 = p - 7'd117;
        end
        else
        begin
            seg  = SEG_STOP;
            off7 = p - 7'd120;
        end
        off = off7[4:0];

        if (st.phase != 7'd0)
        begin
            busy = 1'b1;
            case (seg)
                SEG_START:
                begin
                    case (off)
                        5'd0:    st.sda = 1'b1;
                        5'd1:    st.scl = 1'b1;
                        5'd2:    st.sda = 1'b0;
                        default: st.scl = 1'b0;
                    endcase
                end
                SEG_SEND:
                begin
                    if (off < 5'd24)
                    begin
                        dq = div3(off);
                        case (dq.rem)
                            2'd0:    st.sda = tx_byte[3'd7 - dq.quot];
                            2'd1:    st.scl = 1'b1;
                            default: st.scl = 1'b0;
                        endcase
                    end
                    else
                    begin
                        case (off)
                            5'd24:   st.sda = 1'b1;
                            5'd25:   st.scl = 1'b1;
                            5'd26:
                            begin
                                if (item.sda_in)
                                begin
                                    st.nack = 1'b1;
                                end
                            end
                            default: st.scl = 1'b0;
                        endcase
                    end
                end
                SEG_RECV:
                begin
                    if (off == 5'd0)
                    begin
                        st.sda = 1'b1;
                    end
                    else
                    begin
                        q5 = off - 5'd1;
                        dq = div3(q5);
                        case (dq.rem)
                            2'd0:    st.scl = 1'b1;
                            2'd1:
                            begin
                                if (item.sda_in)
                                begin
                                    st.shift[3'd7 - dq.quot] = 1'b1;
                                end
                            end
                            default: st.scl = 1'b0;
                        endcase
                    end
                end
                SEG_MNACK:
                begin
                    case (off)
                        5'd0:    st.sda = 1'b1;
                        5'd1:    st.scl = 1'b1;
                        default: st.scl = 1'b0;
                    endcase
                end
                SEG_STOP:
                begin
                    case (off)
                        5'd0:    st.sda = 1'b0;
                        5'd1:    st.scl = 1'b1;
                        default: st.sda = 1'b1;
                    endcase
                end
                default:
                begin
                    st.scl = cur.scl;
                end
            endcase

            total = st.kind ? READ_TICKS : WRITE_TICKS;
            done  = (p == total - 7'd1);
            st.phase = done ? 7'd0 : st.phase + 7'd1;
        end

        nxt           = st;
        res.scl_out   = st.scl;
        res.sda_out   = st.sda;
        res.busy_res  = busy;
        res.done_res  = done;
        res.read_data = st.shift;
        res.nack_seen = st.nack;
    end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// Top level of the I2C register access master: input register, sequencer state and
// result register around i2cra_step. Depends on i2cra_pkg and assert_macros.svh.
//
// Each input beat is one bus timing tick and yields exactly one result beat carrying
// the SCL and SDA levels, busy, done, the received byte and the sticky NACK flag.
// A beat passes from the input register through the combinational sequencer step
// into the result register, so one beat is taken every clock cycle while the output
// side is ready. A register write spans 91 ticks and a register read 123 ticks;
// requests that arrive while a transaction runs are ignored.
`include "assert_macros.svh"

module i2c_register_access_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dev_addr [7:0], reg_addr [15:8], wdata [23:16], sda_in [24], zero [31:25]
    input  logic [31:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_out [0], sda_out [1], busy_res [2], done_res [3], read_data [11:4],
    // nack_seen [12], zero [15:13]
    output logic [15:0] m_axis_tdata
);
    import i2cra_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    i2cra_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: 7'd0, kind: 1'b0, addr: 8'h00, regad: 8'h00,
                               data: 8'h00, shift: 8'h00, scl: 1'b1, sda: 1'b1,
                               nack: 1'b0};
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.req_type <= s_axis_tuser;
            in_item_reg.dev_addr <= s_axis_tdata[7:0];
            in_item_reg.reg_addr <= s_axis_tdata[15:8];
            in_item_reg.wdata    <= s_axis_tdata[23:16];
            in_item_reg.sda_in   <= s_axis_tdata[24];
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res_reg.nack_seen, out_res_reg.read_data,
                            out_res_reg.done_res, out_res_reg.busy_res,
                            out_res_reg.sda_out, out_res_reg.scl_out};

    // The sequencer moves only when a beat goes from the input to the result register.
    `ASSERT_NEXT(a_state_holds, clk, rst_n, in_valid_reg && !advance, $stable(state_reg), "sequencer state changed without a beat")
    // Within a transaction the phase counts up by one or returns to idle.
    `ASSERT_NEXT(a_phase_step, clk, rst_n, advance && state_reg.phase != 7'd0, state_reg.phase == 7'd0 || state_reg.phase == $past(state_reg.phase) + 7'd1, "phase skipped a step")
    // Between transactions both bus lines are released.
    `ASSERT_IMPLY(a_idle_released, clk, rst_n, state_reg.phase == 7'd0, state_reg.scl && state_reg.sda, "bus lines not released while idle")

endmodule
